FILE: rtl/differential_drive_odometry_top_macros.svh
// Assertion macros shared by the odometry checker.
// Depends on nothing; expects aclk and aresetn in the using scope.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define DDO_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("odometry assertion failed");

// Next-cycle implication, off while reset is asserted
`define DDO_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("odometry assertion failed");

// Next-cycle implication that also holds through reset
`define DDO_ASSERT_ALWAYS(name, ante, cons) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("odometry assertion failed");

`endif

FILE: rtl/ddo_pkg.sv
// Shared types, constants and the arctangent table of the odometry block.
// Depends on nothing.
package ddo_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > ATAN_ENTRIES) ?
                                       ATAN_ENTRIES : CORDIC_ITERATIONS;
    localparam int REDUCE_STEPS      = 10;

    // Angles in Q3.29
    localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
    localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic [41:0]        TWO_PI_WIDE = 42'd3373259426;

    localparam logic signed [19:0] CORDIC_K_Q16 = 20'sd39797;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DIST_PER_COUNT  = 2'd0,
        CFG_ANGLE_PER_COUNT = 2'd1,
        CFG_HEADING_GAIN    = 2'd2,
        CFG_TICKS_PER_SEC   = 2'd3
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_TURN,
        ST_DELTA,
        ST_MUL_ANG,
        ST_MUL_MID,
        ST_MUL_DIST,
        ST_CAPTURE,
        ST_REDUCE,
        ST_RANGE,
        ST_FOLD,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_POS_Y,
        ST_FINISH
    } state_t;

    // Control of the shared multiplier
    typedef struct packed {
        logic en;
        logic first;
    } mul_ctrl_t;

    // Status of the CORDIC unit
    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/differential_drive_odometry_top.sv
// Odometry top: the block cannot take a new request before it is through with the
// last one. The sequencer makes six passes through the shared multiplier, a
// 10-step angle reduction and a CORDIC pass. s_ready is high only while the
// sequencer is idle; a stalled result holds the sequencer in its last state.
// Synchronous active-low reset clears heading, position and the configuration
// registers to their defaults; outputs go invalid.
module differential_drive_odometry_top (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_wdata,
    // input requests
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [7:0]   s_right_count,
    input  logic signed [7:0]   s_left_count,
    input  logic signed [1:0]   s_right_cmd_sign,
    input  logic signed [1:0]   s_left_cmd_sign,
    // results
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [47:0]  m_pos_x,
    output logic signed [47:0]  m_pos_y,
    output logic signed [8:0]   m_lin_halves,
    output logic signed [31:0]  m_turn_rate,
    output logic signed [31:0]  m_mid_heading,
    output logic signed [31:0]  m_wrapped_heading
);

    ddo_pkg::state_t state_reg, state_next;
    logic            phase_reg;
    logic [3:0]      k_reg;

    // configuration registers
    logic [23:0] dist_per_count_reg;
    logic [23:0] angle_per_count_reg;
    logic [23:0] heading_gain_reg;
    logic [15:0] ticks_per_sec_reg;

    // state
    logic signed [31:0] heading_reg;
    logic signed [47:0] pos_x_reg;
    logic signed [47:0] pos_y_reg;

    // working registers
    logic signed [8:0]  sum_reg;
    logic signed [10:0] dist_reg;
    logic signed [9:0]  turn_reg;
    logic signed [31:0] delta_reg;
    logic signed [32:0] mid_reg;
    logic signed [32:0] newh_reg;
    logic signed [31:0] hnew_reg;
    logic signed [31:0] ang_reg;
    logic signed [41:0] theta_reg;
    logic signed [34:0] p_reg;
    logic        [41:0] rem_reg;
    logic               tneg_reg;
    logic signed [33:0] r_reg;
    logic               fold_reg;
    logic signed [19:0] c_reg, s_reg;
    logic signed [30:0] dx_reg, dy_reg;

    logic                  m_valid_reg;
    logic signed [47:0]    out_pos_x_reg, out_pos_y_reg;
    logic signed [8:0]     out_lin_reg;
    logic signed [31:0]    out_ang_reg, out_mid_reg, out_wrap_reg;

    // shared units
    ddo_pkg::mul_ctrl_t    mul_ctrl;
    logic signed [35:0]    mul_a;
    logic signed [25:0]    mul_b;
    logic signed [61:0]    mul_acc;
    logic                  cordic_start;
    logic signed [33:0]    cordic_z;
    ddo_pkg::cordic_stat_t cordic_stat;
    logic signed [19:0]    cordic_cos, cordic_sin;

    ddo_mul u_mul (
        .aclk    (aclk),
        .ctrl    (mul_ctrl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .mul_acc (mul_acc)
    );

    ddo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .z_in    (cordic_z),
        .stat    (cordic_stat),
        .cos_out (cordic_cos),
        .sin_out (cordic_sin)
    );

    // Input decode
    logic               rp, rn, lp, ln;
    logic signed [8:0]  in_sum, in_diff;
    logic signed [10:0] in_dist;
    logic signed [9:0]  in_turn;
    logic               accept_in;
    logic               out_free;

    always_comb begin
        rp      = (s_right_cmd_sign == 2'sd1);
        rn      = s_right_cmd_sign[1];
        lp      = (s_left_cmd_sign == 2'sd1);
        ln      = s_left_cmd_sign[1];
        in_sum  = 9'(s_right_count) + 9'(s_left_count);
        in_diff = 9'(s_right_count) - 9'(s_left_count);
        in_dist = '0;
        in_turn = '0;
        if (rp && lp) begin
            in_dist = 11'(in_sum);
        end else if (rn && ln) begin
            in_dist = -11'(in_sum);
        end else if (rn && lp) begin
            in_dist = -(11'(in_diff) <<< 1);
            in_turn = -10'(in_sum);
        end else if (rp && ln) begin
            in_dist = 11'(in_diff) <<< 1;
            in_turn = 10'(in_sum);
        end
    end

    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Rounding and saturation of accumulator results, heading wrap, angle fold and position sums
    logic signed [61:0] acc_rnd3, acc_rnd13, acc_rnd16, acc_rnd25;
    logic signed [48:0] ang_wide;
    logic signed [31:0] ang_sat;
    logic signed [33:0] newh_wrap;
    logic signed [31:0] newh_sat;
    logic signed [41:0] theta_abs;
    logic        [41:0] reduce_sub;
    logic signed [33:0] rem_s;
    logic signed [33:0] r_fold;
    logic               fold_flag;
    logic signed [48:0] pos_y_sum;
    logic signed [47:0] pos_y_sat;
    logic signed [48:0] pos_x_sum;
    logic signed [47:0] pos_x_sat;
    logic signed [32:0] mid_out;

    always_comb begin
        acc_rnd3  = mul_acc + 62'sd4;
        acc_rnd13 = mul_acc + 62'sd4096;
        acc_rnd16 = mul_acc + 62'sd32768;
        acc_rnd25 = mul_acc + 62'sd16777216;

        ang_wide = acc_rnd13[61:13];
        if (!ang_wide[48] && (|ang_wide[47:31])) begin
            ang_sat = 32'sh7FFFFFFF;
        end else if (ang_wide[48] && !(&ang_wide[47:31])) begin
            ang_sat = 32'sh80000000;
        end else begin
            ang_sat = ang_wide[31:0];
        end

        // heading wrap by one turn, then clamp
        if (34'(newh_reg) > ddo_pkg::PI_Q29) begin
            newh_wrap = 34'(newh_reg) - ddo_pkg::TWO_PI_Q29;
        end else if (34'(newh_reg) < -ddo_pkg::PI_Q29) begin
            newh_wrap = 34'(newh_reg) + ddo_pkg::TWO_PI_Q29;
        end else begin
            newh_wrap = 34'(newh_reg);
        end
        if (!newh_wrap[33] && (|newh_wrap[32:31])) begin
            newh_sat = 32'sh7FFFFFFF;
        end else if (newh_wrap[33] && !(&newh_wrap[32:31])) begin
            newh_sat = 32'sh80000000;
        end else begin
            newh_sat = newh_wrap[31:0];
        end

        theta_abs  = theta_reg[41] ? -theta_reg : theta_reg;
        reduce_sub = ddo_pkg::TWO_PI_WIDE << k_reg;

        // remainder back to signed range [-pi, pi]
        rem_s = $signed({2'b0, rem_reg[31:0]});
        if (rem_s > ddo_pkg::PI_Q29) begin
            r_fold = tneg_reg ? ddo_pkg::TWO_PI_Q29 - rem_s : rem_s - ddo_pkg::TWO_PI_Q29;
        end else begin
            r_fold = tneg_reg ? -rem_s : rem_s;
        end

        // fold into [-pi/2, pi/2]
        fold_flag = 1'b0;
        cordic_z  = r_reg <<< 1;
        if (r_reg > ddo_pkg::HALF_PI_Q29) begin
            fold_flag = 1'b1;
            cordic_z  = (r_reg - ddo_pkg::PI_Q29) <<< 1;
        end else if (r_reg < -ddo_pkg::HALF_PI_Q29) begin
            fold_flag = 1'b1;
            cordic_z  = (r_reg + ddo_pkg::PI_Q29) <<< 1;
        end

        pos_x_sum = 49'(pos_x_reg) + 49'(dx_reg);
        if (!pos_x_sum[48] && pos_x_sum[47]) begin
            pos_x_sat = 48'sh7FFFFFFFFFFF;
        end else if (pos_x_sum[48] && !pos_x_sum[47]) begin
            pos_x_sat = 48'sh800000000000;
        end else begin
            pos_x_sat = pos_x_sum[47:0];
        end
        pos_y_sum = 49'(pos_y_reg) + 49'(dy_reg);
        if (!pos_y_sum[48] && pos_y_sum[47]) begin
            pos_y_sat = 48'sh7FFFFFFFFFFF;
        end else if (pos_y_sum[48] && !pos_y_sum[47]) begin
            pos_y_sat = 48'sh800000000000;
        end else begin
            pos_y_sat = pos_y_sum[47:0];
        end

        mid_out = mid_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::ST_IDLE:     if (accept_in) state_next = ddo_pkg::ST_MUL_TURN;
            ddo_pkg::ST_MUL_TURN: if (phase_reg) state_next = ddo_pkg::ST_DELTA;
            ddo_pkg::ST_DELTA:    state_next = ddo_pkg::ST_MUL_ANG;
            ddo_pkg::ST_MUL_ANG:  if (phase_reg) state_next = ddo_pkg::ST_MUL_MID;
            ddo_pkg::ST_MUL_MID:  if (phase_reg) state_next = ddo_pkg::ST_MUL_DIST;
            ddo_pkg::ST_MUL_DIST: if (phase_reg) state_next = ddo_pkg::ST_CAPTURE;
            ddo_pkg::ST_CAPTURE:  state_next = ddo_pkg::ST_REDUCE;
            ddo_pkg::ST_REDUCE:   if (k_reg == 4'd0) state_next = ddo_pkg::ST_RANGE;
            ddo_pkg::ST_RANGE:    state_next = ddo_pkg::ST_FOLD;
            ddo_pkg::ST_FOLD:     state_next = ddo_pkg::ST_CORDIC;
            ddo_pkg::ST_CORDIC:   if (cordic_stat.done) state_next = ddo_pkg::ST_MUL_X;
            ddo_pkg::ST_MUL_X:    if (phase_reg) state_next = ddo_pkg::ST_MUL_Y;
            ddo_pkg::ST_MUL_Y:    if (phase_reg) state_next = ddo_pkg::ST_POS_Y;
            ddo_pkg::ST_POS_Y:    state_next = ddo_pkg::ST_FINISH;
            ddo_pkg::ST_FINISH:   if (out_free) state_next = ddo_pkg::ST_IDLE;
            default:              state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready      = 1'b0;
        mul_ctrl     = '{en: 1'b0, first: !phase_reg};
        mul_a        = '0;
        mul_b        = '0;
        cordic_start = 1'b0;
        case (state_reg)
            ddo_pkg::ST_IDLE: s_ready = 1'b1;
            ddo_pkg::ST_MUL_TURN: begin
                mul_ctrl.en = 1'b1;
                mul_a       = 36'(turn_reg);
                mul_b       = $signed({2'b0, angle_per_count_reg});
            end
            ddo_pkg::ST_MUL_ANG: begin
                mul_ctrl.en = 1'b1;
                mul_a       = 36'(delta_reg);
                mul_b       = $signed({10'b0, ticks_per_sec_reg});
            end
            ddo_pkg::ST_MUL_MID: begin
                mul_ctrl.en = 1'b1;
                mul_a       = 36'(mid_reg);
                mul_b       = $signed({2'b0, heading_gain_reg});
            end
            ddo_pkg::ST_MUL_DIST: begin
                mul_ctrl.en = 1'b1;
                mul_a       = 36'(dist_reg);
                mul_b       = $signed({2'b0, dist_per_count_reg});
            end
            ddo_pkg::ST_FOLD: cordic_start = 1'b1;
            ddo_pkg::ST_MUL_X: begin
                mul_ctrl.en = 1'b1;
                mul_a       = 36'(p_reg);
                mul_b       = 26'(c_reg);
            end
            ddo_pkg::ST_MUL_Y: begin
                mul_ctrl.en = 1'b1;
                mul_a       = 36'(p_reg);
                mul_b       = 26'(s_reg);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ddo_pkg::ST_IDLE;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= mul_ctrl.en ? !phase_reg : 1'b0;
            if (state_reg == ddo_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration and odometry state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_per_count_reg  <= 24'd2738400;
            angle_per_count_reg <= 24'd2105180;
            heading_gain_reg    <= 24'd380764;
            ticks_per_sec_reg   <= 16'd200;
            heading_reg         <= '0;
            pos_x_reg           <= '0;
            pos_y_reg           <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (ddo_pkg::cfg_index_t'(cfg_index))
                    ddo_pkg::CFG_DIST_PER_COUNT:  dist_per_count_reg  <= cfg_wdata;
                    ddo_pkg::CFG_ANGLE_PER_COUNT: angle_per_count_reg <= cfg_wdata;
                    ddo_pkg::CFG_HEADING_GAIN:    heading_gain_reg    <= cfg_wdata;
                    ddo_pkg::CFG_TICKS_PER_SEC:   ticks_per_sec_reg   <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ddo_pkg::ST_MUL_Y && phase_reg) begin
                pos_x_reg <= pos_x_sat;
            end
            if (state_reg == ddo_pkg::ST_FINISH && out_free) begin
                pos_y_reg   <= pos_y_sat;
                heading_reg <= hnew_reg;
            end
        end
    end

    // Working datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ddo_pkg::ST_IDLE: begin
                sum_reg  <= in_sum;
                dist_reg <= in_dist;
                turn_reg <= in_turn;
            end
            ddo_pkg::ST_DELTA: delta_reg <= acc_rnd3[34:3];
            ddo_pkg::ST_MUL_ANG: begin
                mid_reg  <= 33'(heading_reg) + 33'(delta_reg >>> 1);
                newh_reg <= 33'(heading_reg) + 33'(delta_reg);
            end
            ddo_pkg::ST_MUL_MID: begin
                if (!phase_reg) begin
                    ang_reg  <= ang_sat;
                    hnew_reg <= newh_sat;
                end
            end
            ddo_pkg::ST_MUL_DIST: if (!phase_reg) theta_reg <= acc_rnd16[57:16];
            ddo_pkg::ST_CAPTURE: begin
                p_reg    <= mul_acc[34:0];
                rem_reg  <= theta_abs;
                tneg_reg <= theta_reg[41];
                k_reg    <= 4'(ddo_pkg::REDUCE_STEPS - 1);
            end
            ddo_pkg::ST_REDUCE: begin
                if (rem_reg >= reduce_sub) begin
                    rem_reg <= rem_reg - reduce_sub;
                end
                k_reg <= k_reg - 4'd1;
            end
            ddo_pkg::ST_RANGE: r_reg <= r_fold;
            ddo_pkg::ST_FOLD:  fold_reg <= fold_flag;
            ddo_pkg::ST_CORDIC: begin
                c_reg <= fold_reg ? -cordic_cos : cordic_cos;
                s_reg <= fold_reg ? -cordic_sin : cordic_sin;
            end
            ddo_pkg::ST_MUL_Y: if (!phase_reg) dx_reg <= acc_rnd25[55:25];
            ddo_pkg::ST_POS_Y: dy_reg <= acc_rnd25[55:25];
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (state_reg == ddo_pkg::ST_FINISH && out_free) begin
            out_pos_x_reg <= pos_x_reg;
            out_pos_y_reg <= pos_y_sat;
            out_lin_reg   <= sum_reg;
            out_ang_reg   <= ang_reg;
            if (!mid_out[32] && mid_out[31]) begin
                out_mid_reg <= 32'sh7FFFFFFF;
            end else if (mid_out[32] && !mid_out[31]) begin
                out_mid_reg <= 32'sh80000000;
            end else begin
                out_mid_reg <= mid_out[31:0];
            end
            out_wrap_reg  <= hnew_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pos_x           = out_pos_x_reg;
    assign m_pos_y           = out_pos_y_reg;
    assign m_lin_halves      = out_lin_reg;
    assign m_turn_rate       = out_ang_reg;
    assign m_mid_heading     = out_mid_reg;
    assign m_wrapped_heading = out_wrap_reg;

endmodule

FILE: rtl/ddo_mul.sv
// Shared signed multiplier: 36-bit operand times a 26-bit operand in two
// 13-bit halves, low half first, into a 62-bit accumulator. Uses ddo_pkg.
module ddo_mul (
    input  logic                  aclk,
    input  ddo_pkg::mul_ctrl_t    ctrl,
    input  logic signed [35:0]    mul_a,
    input  logic signed [25:0]    mul_b,
    output logic signed [61:0]    mul_acc
);

    logic signed [61:0] acc_reg;
    logic signed [61:0] acc_next;
    logic signed [13:0] b_part;
    logic signed [49:0] prod;
    logic signed [61:0] prod_ext;

    // Low half unsigned, high half carries the sign
    always_comb begin
        b_part   = ctrl.first ? $signed({1'b0, mul_b[12:0]}) :
                                $signed({mul_b[25], mul_b[25:13]});
        prod     = mul_a * b_part;
        prod_ext = {{12{prod[49]}}, prod};
        acc_next = ctrl.first ? prod_ext : acc_reg + (prod_ext <<< 13);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign mul_acc = acc_reg;

endmodule

FILE: rtl/ddo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q16 outputs.
// Uses ddo_pkg for the step count, start gain and arctangent table.
module ddo_cordic (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [33:0]     z_in,
    output ddo_pkg::cordic_stat_t  stat,
    output logic signed [19:0]     cos_out,
    output logic signed [19:0]     sin_out
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic        [4:0]  i_reg;
    logic signed [19:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic signed [19:0] sh_x, sh_y;
    logic signed [33:0] atan_v;
    logic               last;

    // One micro-rotation
    always_comb begin
        sh_x   = x_reg >>> i_reg;
        sh_y   = y_reg >>> i_reg;
        atan_v = $signed({4'b0, ddo_pkg::atan_q30(i_reg)});
        last   = (i_reg == 5'(ddo_pkg::CORDIC_STEPS - 1));
    end

    // Control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && last) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= ddo_pkg::CORDIC_K_Q16;
            y_reg <= '0;
            z_reg <= z_in;
            i_reg <= '0;
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - sh_y;
                y_reg <= y_reg + sh_x;
                z_reg <= z_reg - atan_v;
            end else begin
                x_reg <= x_reg + sh_y;
                y_reg <= y_reg - sh_x;
                z_reg <= z_reg + atan_v;
            end
            i_reg <= i_reg + 5'd1;
        end
    end

    assign stat    = '{busy: busy_reg, done: done_reg};
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

FILE: rtl/ddo_checker.sv
// Port-level checker for the odometry block, bound to the top level.
// Depends on differential_drive_odometry_top_macros.svh.
`include "differential_drive_odometry_top_macros.svh"

module ddo_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [47:0] m_pos_x,
    input logic signed [31:0] m_wrapped_heading
);

    // a request holds off further requests while it is worked on
    `DDO_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // a result taken while idle is not followed by another at once
    `DDO_ASSERT_NEXT(a_no_spurious_result, m_valid && m_ready && s_ready, !m_valid)
    // the heading leaves the wrap step inside one half turn
    `DDO_ASSERT_SAME(a_heading_range, m_valid,
        (m_wrapped_heading <= 32'sd1686629713) && (m_wrapped_heading >= -32'sd1686629713))
    // a stalled result holds
    `DDO_ASSERT_NEXT(a_result_stable, m_valid && !m_ready, m_valid && $stable(m_pos_x))
    // reset empties the result register
    `DDO_ASSERT_ALWAYS(a_reset_clears, !aresetn, !m_valid)

endmodule

bind differential_drive_odometry_top ddo_checker u_ddo_checker (.*);

FILE: test/tb_differential_drive_odometry_top.sv
// Testbench for the differential-drive odometry block: random and directed
// encoder requests with a self-checking scoreboard. Depends on ddo_pkg and
// differential_drive_odometry_top.
module tb_differential_drive_odometry_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct packed {
        logic signed [7:0] right_count;
        logic signed [7:0] left_count;
        logic signed [1:0] right_sign;
        logic signed [1:0] left_sign;
    } odo_req_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [8:0]  lin_speed;
        logic signed [31:0] ang_speed;
        logic signed [31:0] mid_heading;
        logic signed [31:0] wrap_heading;
    } odo_res_t;

    // Tracks odometry state and the queue of expected poses
    class odo_scoreboard;
        longint unsigned dist_per_count, angle_per_count, gain, ticks;
        longint heading, pos_x, pos_y;
        odo_res_t pose_q[$];
        int mismatches;
        longint atan_tab[24] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};

        function new();
            dist_per_count = 2738400; angle_per_count = 2105180;
            gain = 380764; ticks = 200;
            heading = 0; pos_x = 0; pos_y = 0; mismatches = 0;
        endfunction

        function void write_reg(ddo_pkg::cfg_index_t idx, logic [23:0] val);
            case (idx)
                ddo_pkg::CFG_DIST_PER_COUNT:  dist_per_count  = val;
                ddo_pkg::CFG_ANGLE_PER_COUNT: angle_per_count = val;
                ddo_pkg::CFG_HEADING_GAIN:    gain            = val;
                ddo_pkg::CFG_TICKS_PER_SEC:   ticks           = val[15:0];
                default: ;
            endcase
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Angle reduction, quadrant fold and rotation-mode CORDIC in Q16
        function void cordic(longint theta, output longint c, output longint s);
            longint r, x, y, z, nx;
            bit flip;
            r = theta % 64'sd3373259426;
            x = 39797; y = 0; flip = 0;
            if (r > 64'sd1686629713) r -= 64'sd3373259426;
            if (r < -64'sd1686629713) r += 64'sd3373259426;
            if (r > 64'sd843314857) begin
                r -= 64'sd1686629713; flip = 1;
            end else if (r < -64'sd843314857) begin
                r += 64'sd1686629713; flip = 1;
            end
            z = r * 2;
            for (int i = 0; i < ddo_pkg::CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
                end else begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // Predict the pose produced by one accepted request
        function void note_request(odo_req_t rq);
            longint r, l, sum, diff, travel, turn, delta, mid, newh, theta, c, s, ang;
            bit rp, rn, lp, ln;
            odo_res_t e;
            r = rq.right_count; l = rq.left_count;
            rp = rq.right_sign == 2'b01; rn = rq.right_sign[1];
            lp = rq.left_sign == 2'b01;  ln = rq.left_sign[1];
            sum = r + l; diff = r - l; travel = 0; turn = 0;
            if (rp && lp) travel = sum;
            else if (rn && ln) travel = -sum;
            else if (rn && lp) begin travel = -2 * diff; turn = -sum; end
            else if (rp && ln) begin travel = 2 * diff; turn = sum; end
            delta = (turn * longint'(angle_per_count) + 4) >>> 3;
            mid = heading + (delta >>> 1);
            newh = heading + delta;
            theta = (mid * longint'(gain) + 32768) >>> 16;
            cordic(theta, c, s);
            pos_x = sat(pos_x + ((travel * longint'(dist_per_count) * c + (64'sd1 << 24)) >>> 25),
                        -(64'sd1 << 47), (64'sd1 << 47) - 1);
            pos_y = sat(pos_y + ((travel * longint'(dist_per_count) * s + (64'sd1 << 24)) >>> 25),
                        -(64'sd1 << 47), (64'sd1 << 47) - 1);
            ang = sat((delta * longint'(ticks) + 4096) >>> 13, -(64'sd1 << 31), (64'sd1 << 31) - 1);
            if (newh > 64'sd1686629713) newh -= 64'sd3373259426;
            else if (newh < -64'sd1686629713) newh += 64'sd3373259426;
            newh = sat(newh, -(64'sd1 << 31), (64'sd1 << 31) - 1);
            heading = newh;
            e.pos_x = 48'(pos_x); e.pos_y = 48'(pos_y);
            e.lin_speed = 9'(sum); e.ang_speed = 32'(ang);
            e.mid_heading = 32'(sat(mid, -(64'sd1 << 31), (64'sd1 << 31) - 1));
            e.wrap_heading = 32'(newh);
            pose_q.push_back(e);
        endfunction

        function void cmp(string fname, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %s: expected %0h got %0h", fname, want, got);
            end
        endfunction

        function void check_result(odo_res_t got);
            odo_res_t e;
            if (pose_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %p", got);
                return;
            end
            e = pose_q.pop_front();
            cmp("pos_x", e.pos_x, got.pos_x);
            cmp("pos_y", e.pos_y, got.pos_y);
            cmp("lin_halves", {{39{e.lin_speed[8]}}, e.lin_speed},
                {{39{got.lin_speed[8]}}, got.lin_speed});
            cmp("turn_rate", 48'(e.ang_speed), 48'(got.ang_speed));
            cmp("mid_heading", 48'(e.mid_heading), 48'(got.mid_heading));
            cmp("wrapped_heading", 48'(e.wrap_heading), 48'(got.wrap_heading));
        endfunction
    endclass

    logic               aclk, aresetn;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_wdata;
    logic               s_valid, s_ready, m_valid, m_ready;
    logic signed [7:0]  s_right_count, s_left_count;
    logic signed [1:0]  s_right_cmd_sign, s_left_cmd_sign;
    logic signed [47:0] m_pos_x, m_pos_y;
    logic signed [8:0]  m_lin_halves;
    logic signed [31:0] m_turn_rate, m_mid_heading, m_wrapped_heading;

    odo_scoreboard sb = new();
    bit idle_on;
    int stall_cycles;

    differential_drive_odometry_top u_dut (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Watch both handshakes; feed the scoreboard
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_request('{s_right_count, s_left_count, s_right_cmd_sign, s_left_cmd_sign});
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_pos_x, m_pos_y, m_lin_halves, m_turn_rate,
                              m_mid_heading, m_wrapped_heading});
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge aclk)
        m_ready <= !(idle_on && $urandom_range(99) < 7);

    task automatic write_reg(ddo_pkg::cfg_index_t idx, logic [23:0] val);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Let the monitor see the last edge before looking at the queue
    task automatic wait_drained();
        @(posedge aclk);
        while (sb.pose_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(logic [23:0] dpc, logic [23:0] apc, logic [23:0] hg,
                             logic [23:0] tps);
        s_valid <= 1'b0;
        wait_drained();
        write_reg(ddo_pkg::CFG_DIST_PER_COUNT, dpc);
        write_reg(ddo_pkg::CFG_ANGLE_PER_COUNT, apc);
        write_reg(ddo_pkg::CFG_HEADING_GAIN, hg);
        write_reg(ddo_pkg::CFG_TICKS_PER_SEC, tps);
    endtask

    // Present one request; valid stays high into the next one unless a gap comes
    task automatic send_request(logic [7:0] rc, logic [7:0] lc, logic [1:0] rs, logic [1:0] ls);
        if (idle_on && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_right_count <= rc; s_left_count <= lc;
        s_right_cmd_sign <= rs; s_left_cmd_sign <= ls;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) begin
            idle_on = !(i >= n / 3 && i < n / 2);
            send_request(8'($urandom), 8'($urandom), 2'($urandom_range(3)),
                         2'($urandom_range(3)));
        end
        idle_on = 1;
    endtask

    initial begin
        logic [7:0] edge_counts[4];
        edge_counts = '{8'h7F, 8'h80, 8'h00, 8'hFF};
        aresetn = 0; cfg_wr_en = 0; cfg_index = 0; cfg_wdata = 0;
        s_valid = 0; s_right_count = 0; s_left_count = 0;
        s_right_cmd_sign = 0; s_left_cmd_sign = 0;
        idle_on = 1; stall_cycles = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: count extremes over every command-sign pattern
        for (int sp = 0; sp < 16; sp++)
            send_request(edge_counts[sp % 4], edge_counts[(sp / 4 + sp) % 4],
                         sp[3:2], sp[1:0]);
        send_request(8'h7F, 8'h80, 2'b01, 2'b11);
        send_request(8'h80, 8'h7F, 2'b11, 2'b01);
        send_request(8'h7F, 8'h7F, 2'b10, 2'b10);
        random_burst(300);

        // Extremes: all zero, then all ones
        configure(24'h0, 24'h0, 24'h0, 24'h0);
        random_burst(200);
        configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF);
        random_burst(300);
        // Random registers, first with ticks-per-second zero, then nonzero
        configure(24'($urandom), 24'($urandom), 24'($urandom), 24'h0);
        random_burst(300);
        configure(24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom_range(1, 65535)));
        random_burst(200);

        // Hold the sender off until every pose is back
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pose_q.size() != 0) @(posedge aclk);
        configure(24'd2738400, 24'd2105180, 24'd380764, 24'd200);
        random_burst(200);

        s_valid <= 1'b0;
        wait_drained();
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_mul.sv
rtl/ddo_cordic.sv
rtl/differential_drive_odometry_top.sv
rtl/ddo_checker.sv
test/tb_differential_drive_odometry_top.sv
